// File: hw/rtl/plat_pkg.sv
// shared types and constants for the polyline arc length truncation block
// no dependencies
`timescale 1ns / 1ps

package plat_pkg;

	localparam int CORDIC_STEPS = 20;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_SQ,
		ST_ROOT,
		ST_DECIDE,
		ST_MULR,
		ST_DIV,
		ST_APPLY,
		ST_EMIT
	} state_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0: v = 32'd536870912;
			5'd1: v = 32'd316933406;
			5'd2: v = 32'd167458907;
			5'd3: v = 32'd85004756;
			5'd4: v = 32'd42667331;
			5'd5: v = 32'd21354465;
			5'd6: v = 32'd10680862;
			5'd7: v = 32'd5340245;
			5'd8: v = 32'd2670163;
			5'd9: v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/polyline_arc_length_truncate.sv
// polyline truncation by arc length, top level
// depends on plat_pkg
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata x,y; tuser first_point; tlast end_of_path
// m_axis    out  m_axis_tvalid/tready      tdata x,y,seg,heading,total; tuser interp; tlast
// cfg       in   cfg_wr_en                 cfg_wr_data = max_length
//
// after acceptance a request passes through these steps in order:
// a difference step, 4 multiply steps, 33 square root steps (cordic runs alongside),
// a decision step and the output load; a first point goes straight to the output load
// an interpolated point adds multiply, divide and apply steps for each axis in turn on the shared divider
// s_axis_tready is high only in idle; a result waits in the output register
// reset is asynchronous and clears control state and max_length to 10.0
`timescale 1ns / 1ps

module polyline_arc_length_truncate #(
	parameter int COORD_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // point_x, point_y
	input  logic         s_axis_tuser,  // first_point
	input  logic         s_axis_tlast,  // end_of_path
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,  // kept_x, kept_y, segment_length, segment_heading,
	                                    // total_length
	output logic         m_axis_tuser,  // interpolated
	output logic         m_axis_tlast,  // last
	input  logic         cfg_wr_en,
	input  logic [31:0]  cfg_wr_data
);

	localparam int EffW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

	plat_pkg::state_t state_q, state_d;

	logic [5:0]         cnt_q;
	logic               axis_q;
	logic [31:0]        max_q;
	logic               stopped_q;
	logic signed [33:0] prev_x_q, prev_y_q;
	logic [31:0]        acc_len_q;

	logic signed [33:0] cx_q, cy_q, dx_q, dy_q;
	logic               eop_q;
	logic [32:0]        ax_q, ay_q;
	logic [65:0]        prod_q;
	logic [65:0]        sum_q;
	logic [34:0]        rt_rem_q;
	logic [32:0]        rt_res_q;
	logic signed [36:0] cx_c_q, cy_c_q;
	logic [31:0]        z_q;
	logic [31:0]        rem_q;
	logic [32:0]        div_r_q;
	logic [65:0]        div_num_q;
	logic [33:0]        quo_q;

	logic [31:0] r_x_q, r_y_q, r_seg_q, r_tot_q;
	logic [15:0] r_head_q;
	logic        r_interp_q, r_last_q;

	logic [31:0] o_x_q, o_y_q, o_seg_q, o_tot_q;
	logic [15:0] o_head_q;
	logic        o_interp_q, o_last_q, o_valid_q;

	logic signed [33:0] in_x, in_y;
	logic               accept;
	logic               emit_go;

	// shared multiplier
	logic [32:0] mul_a;
	logic [16:0] mul_b;
	logic        mul_clr, mul_hi;
	logic [49:0] mul_p;
	logic [65:0] mul_term;

	// decision
	logic [33:0] total;
	logic        over;
	logic [31:0] rem_v;
	logic [31:0] zsum;

	// root step
	logic [36:0] rt_x, rt_trial;
	logic        rt_ge;

	// cordic step
	logic [4:0]         cd_i;
	logic signed [36:0] cd_xs, cd_ys;

	// divide step
	logic [65:0] dv_num;
	logic [32:0] dv_r;
	logic [33:0] dv_r2;
	logic        dv_ge;

	// apply
	logic signed [34:0] ap_off, ap_base, ap_pos;

	assign in_x = {{(34 - EffW){s_axis_tdata[EffW - 1]}}, s_axis_tdata[EffW - 1:0]};
	assign in_y = {{(34 - EffW){s_axis_tdata[32 + EffW - 1]}}, s_axis_tdata[32 + EffW - 1:32]};
	assign s_axis_tready = (state_q == plat_pkg::ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign emit_go = (state_q == plat_pkg::ST_EMIT) && (!o_valid_q || m_axis_tready);

	always_comb begin
		mul_a = ax_q;
		mul_b = ax_q[16:0];
		mul_clr = 1'b0;
		mul_hi = cnt_q[0];
		if (state_q == plat_pkg::ST_SQ) begin
			mul_a = cnt_q[1] ? ay_q : ax_q;
			mul_b = cnt_q[0] ? {1'b0, mul_a[32:17]} : mul_a[16:0];
			mul_clr = (cnt_q == 6'd0);
		end else begin
			mul_a = axis_q ? ay_q : ax_q;
			mul_b = cnt_q[0] ? {2'b0, rem_q[31:17]} : rem_q[16:0];
			mul_clr = (cnt_q == 6'd0);
		end
		mul_p = {17'b0, mul_a} * {33'b0, mul_b};
		mul_term = mul_hi ? ({16'b0, mul_p} << 17) : {16'b0, mul_p};
	end

	always_comb begin
		total = {2'b0, acc_len_q} + {1'b0, rt_res_q};
		over = total > {2'b0, max_q};
		rem_v = (acc_len_q >= max_q) ? 32'd0 : (max_q - acc_len_q);
		zsum = z_q + 32'h8000;
	end

	always_comb begin
		rt_x = {rt_rem_q, (cnt_q == 6'd0) ? prod_q[65:64] : sum_q[65:64]};
		rt_trial = {2'b0, rt_res_q, 2'b01};
		rt_ge = rt_x >= rt_trial;
		cd_i = cnt_q[4:0];
		cd_xs = cx_c_q >>> cd_i;
		cd_ys = cy_c_q >>> cd_i;
	end

	always_comb begin
		dv_num = (cnt_q == 6'd0) ? (prod_q + {34'b0, rt_res_q[32:1]}) : div_num_q;
		dv_r = (cnt_q == 6'd0) ? {1'b0, dv_num[65:34]} : div_r_q;
		dv_r2 = {dv_r, dv_num[33]};
		dv_ge = dv_r2 >= {1'b0, rt_res_q};
	end

	always_comb begin
		ap_off = $signed({1'b0, quo_q});
		if (axis_q) begin
			ap_base = {prev_y_q[33], prev_y_q};
			ap_pos = dy_q[33] ? (ap_base - ap_off) : (ap_base + ap_off);
		end else begin
			ap_base = {prev_x_q[33], prev_x_q};
			ap_pos = dx_q[33] ? (ap_base - ap_off) : (ap_base + ap_off);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			plat_pkg::ST_IDLE: begin
				if (accept) begin
					if (s_axis_tuser) state_d = plat_pkg::ST_EMIT;
					else if (!stopped_q) state_d = plat_pkg::ST_PREP;
				end
			end
			plat_pkg::ST_PREP: state_d = plat_pkg::ST_SQ;
			plat_pkg::ST_SQ: if (cnt_q == 6'd3) state_d = plat_pkg::ST_ROOT;
			plat_pkg::ST_ROOT: if (cnt_q == 6'd32) state_d = plat_pkg::ST_DECIDE;
			plat_pkg::ST_DECIDE: begin
				if (over && (rt_res_q != 33'd0)) state_d = plat_pkg::ST_MULR;
				else state_d = plat_pkg::ST_EMIT;
			end
			plat_pkg::ST_MULR: if (cnt_q == 6'd1) state_d = plat_pkg::ST_DIV;
			plat_pkg::ST_DIV: if (cnt_q == 6'd33) state_d = plat_pkg::ST_APPLY;
			plat_pkg::ST_APPLY: state_d = axis_q ? plat_pkg::ST_EMIT : plat_pkg::ST_MULR;
			plat_pkg::ST_EMIT: if (emit_go) state_d = plat_pkg::ST_IDLE;
			default: state_d = plat_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plat_pkg::ST_IDLE;
			cnt_q <= 6'd0;
			axis_q <= 1'b0;
			max_q <= 32'd655360;
			stopped_q <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			acc_len_q <= 32'd0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_d != state_q) ? 6'd0 : cnt_q + 6'd1;
			if (cfg_wr_en) max_q <= cfg_wr_data;
			if (state_q == plat_pkg::ST_DECIDE) axis_q <= 1'b0;
			else if (state_q == plat_pkg::ST_APPLY) axis_q <= 1'b1;
			if (accept && s_axis_tuser) begin
				prev_x_q <= in_x;
				prev_y_q <= in_y;
				acc_len_q <= 32'd0;
				stopped_q <= s_axis_tlast;
			end
			if (state_q == plat_pkg::ST_DECIDE) begin
				if (over) begin
					stopped_q <= 1'b1;
				end else begin
					prev_x_q <= cx_q;
					prev_y_q <= cy_q;
					acc_len_q <= total[31:0];
					stopped_q <= (total == {2'b0, max_q}) || eop_q;
				end
			end
			if (emit_go) o_valid_q <= 1'b1;
			else if (m_axis_tready) o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= in_x;
			cy_q <= in_y;
			eop_q <= s_axis_tlast;
			if (s_axis_tuser) begin
				r_x_q <= in_x[31:0];
				r_y_q <= in_y[31:0];
				r_seg_q <= 32'd0;
				r_head_q <= 16'd0;
				r_tot_q <= 32'd0;
				r_interp_q <= 1'b0;
				r_last_q <= s_axis_tlast;
			end
		end
		unique case (state_q)
			plat_pkg::ST_PREP: begin
				dx_q <= cx_q - prev_x_q;
				dy_q <= cy_q - prev_y_q;
				ax_q <= (cx_q < prev_x_q) ? 33'(prev_x_q - cx_q) : 33'(cx_q - prev_x_q);
				ay_q <= (cy_q < prev_y_q) ? 33'(prev_y_q - cy_q) : 33'(cy_q - prev_y_q);
			end
			plat_pkg::ST_SQ, plat_pkg::ST_MULR: begin
				prod_q <= (mul_clr ? 66'd0 : prod_q) + mul_term;
				if (state_q == plat_pkg::ST_SQ && cnt_q == 6'd3) begin
					rt_rem_q <= '0;
					rt_res_q <= '0;
					if (dx_q < 0) begin
						cx_c_q <= -{{3{dx_q[33]}}, dx_q};
						cy_c_q <= -{{3{dy_q[33]}}, dy_q};
						z_q <= 32'h8000_0000;
					end else begin
						cx_c_q <= {{3{dx_q[33]}}, dx_q};
						cy_c_q <= {{3{dy_q[33]}}, dy_q};
						z_q <= 32'd0;
					end
				end
			end
			plat_pkg::ST_ROOT: begin
				if (cnt_q == 6'd0) sum_q <= (prod_q << 2);
				else sum_q <= sum_q << 2;
				if (rt_ge) begin
					rt_rem_q <= 35'(rt_x - rt_trial);
					rt_res_q <= {rt_res_q[31:0], 1'b1};
				end else begin
					rt_rem_q <= rt_x[34:0];
					rt_res_q <= {rt_res_q[31:0], 1'b0};
				end
				if (cnt_q < 6'(plat_pkg::CORDIC_STEPS)) begin
					if (cy_c_q > 0) begin
						cx_c_q <= cx_c_q + cd_ys;
						cy_c_q <= cy_c_q - cd_xs;
						z_q <= z_q + plat_pkg::atan_lut(cd_i);
					end else begin
						cx_c_q <= cx_c_q - cd_ys;
						cy_c_q <= cy_c_q + cd_xs;
						z_q <= z_q - plat_pkg::atan_lut(cd_i);
					end
				end
			end
			plat_pkg::ST_DECIDE: begin
				r_head_q <= (dx_q == 34'sd0 && dy_q == 34'sd0) ? 16'd0 : zsum[31:16];
				if (over) begin
					rem_q <= rem_v;
					r_x_q <= prev_x_q[31:0];
					r_y_q <= prev_y_q[31:0];
					r_seg_q <= rem_v;
					r_tot_q <= max_q;
					r_interp_q <= 1'b1;
					r_last_q <= 1'b1;
				end else begin
					r_x_q <= cx_q[31:0];
					r_y_q <= cy_q[31:0];
					r_seg_q <= rt_res_q[32] ? 32'hFFFF_FFFF : rt_res_q[31:0];
					r_tot_q <= total[31:0];
					r_interp_q <= 1'b0;
					r_last_q <= (total == {2'b0, max_q}) || eop_q;
				end
			end
			plat_pkg::ST_DIV: begin
				div_num_q <= dv_num << 1;
				div_r_q <= dv_ge ? 33'(dv_r2 - {1'b0, rt_res_q}) : dv_r2[32:0];
				quo_q <= {quo_q[32:0], dv_ge};
			end
			plat_pkg::ST_APPLY: begin
				if (axis_q) r_y_q <= ap_pos[31:0];
				else r_x_q <= ap_pos[31:0];
			end
			default: begin
			end
		endcase
		if (emit_go) begin
			o_x_q <= r_x_q;
			o_y_q <= r_y_q;
			o_seg_q <= r_seg_q;
			o_head_q <= r_head_q;
			o_tot_q <= r_tot_q;
			o_interp_q <= r_interp_q;
			o_last_q <= r_last_q;
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata = {o_tot_q, o_head_q, o_seg_q, o_y_q, o_x_q};
	assign m_axis_tuser = o_interp_q;
	assign m_axis_tlast = o_last_q;

endmodule

// File: hw/rtl/plat_checker.sv
// port-level checks for polyline_arc_length_truncate
// bound to the top level, no other dependencies
`timescale 1ns / 1ps

module plat_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata,
	input logic         m_axis_tuser,
	input logic         m_axis_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// interpolated point ends the path
	a_interp_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("interpolated point not last");

	// remaining length never exceeds the limit
	a_interp_seg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[95:64] <= m_axis_tdata[143:112])
		else $error("interpolated segment exceeds total");

endmodule

bind polyline_arc_length_truncate plat_checker u_plat_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser),
	.m_axis_tlast(m_axis_tlast)
);
